### hdl/isa_pkg.sv
package isa_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned InW      = FracBits + 1;
  localparam int unsigned OutW     = FracBits + 2;
  localparam int unsigned WBits    = 30;
  localparam int unsigned WW       = WBits + 1;   // u, s in [0, 1.0] Q30
  localparam int unsigned AccW     = 32;          // horner accumulator, below 2.6 in Q30
  localparam int unsigned NCoef    = 10;

  localparam logic [AccW-1:0] Coef [NCoef] = '{
    32'd2147483648, 32'd322122547, 32'd123096831, 32'd61299154, 32'd34676311,
    32'd21151512, 32'd13561632, 32'd9009379, 32'd6146265, 32'd4280423
  };

  localparam logic [AccW-1:0] SqrtThreeHalves = 32'd1315059792;

endpackage

### hdl/inverse_sinc_approx.sv
// throughput: one transaction per cycle while the output is not stalled; 20 register
//   stages, each taking a new one every cycle (entry, 16 square root stages of two root
//   bits each with the nine horner steps beside them, two multiply stages, rounding)
// reset: rst_ni clears all valid bits at once; payload registers are not reset
// a stall holds every stage, so nothing is lost or repeated
module inverse_sinc_approx (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [isa_pkg::InW-1:0]     sinc_value_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [isa_pkg::OutW-1:0]    angle_o
);

  localparam int unsigned WW   = isa_pkg::WW;
  localparam int unsigned AccW = isa_pkg::AccW;
  localparam int unsigned NSq  = 16;   // 32 root steps over a 64-bit radicand, two per stage
  localparam int unsigned RW   = 64;   // radicand / remainder width
  localparam int unsigned L    = NSq + 3; // stages holding data before output

  // global pipeline enable: advance when output not stalled or empty
  logic adv;
  logic [L:0] vld_q;
  assign adv     = !(vld_q[L] && stall_i);
  assign stall_o = !adv;

  // stage 0: saturate and form u in Q30
  logic [isa_pkg::InW-1:0] a_sat;
  logic [WW-1:0]           u0;
  always_comb begin
    a_sat = (sinc_value_i > isa_pkg::InW'(1 << isa_pkg::FracBits))
            ? isa_pkg::InW'(1 << isa_pkg::FracBits) : sinc_value_i;
    u0 = WW'(isa_pkg::InW'(1 << isa_pkg::FracBits) - a_sat)
         << (isa_pkg::WBits - isa_pkg::FracBits);
  end

  // sqrt pipeline: restoring, 2 bits per stage
  logic [RW-1:0] rem_q  [NSq+1];
  logic [WW-1:0] root_q [NSq+1];
  logic [RW-1:0] rad_q  [NSq+1];
  // horner pipeline runs on stages 1..9 in parallel with sqrt
  logic [WW-1:0]   u_q   [NSq+1];
  logic [AccW-1:0] acc_q [NSq+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[L-1:0], valid_i};
    end
  end

  // stage entry
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad_q[0]  <= RW'(u0) << isa_pkg::WBits;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      u_q[0]    <= u0;
      acc_q[0]  <= isa_pkg::Coef[9];
    end
  end

  // sqrt and horner stages
  for (genvar g = 0; g < NSq; g++) begin : g_stage
    logic [RW-1:0]   sh_a, trial_a, rem_a, sh_b, trial_b, rem_b;
    logic [WW-1:0]   root_a, root_b;
    logic [AccW-1:0] acc_n;

    // two restoring root steps, two radicand bits each
    always_comb begin
      sh_a    = {rem_q[g][RW-3:0], rad_q[g][RW-1 -: 2]};
      trial_a = RW'({root_q[g], 2'b01});
      if (sh_a >= trial_a) begin
        rem_a  = sh_a - trial_a;
        root_a = {root_q[g][WW-2:0], 1'b1};
      end else begin
        rem_a  = sh_a;
        root_a = {root_q[g][WW-2:0], 1'b0};
      end
      sh_b    = {rem_a[RW-3:0], rad_q[g][RW-3 -: 2]};
      trial_b = RW'({root_a, 2'b01});
      if (sh_b >= trial_b) begin
        rem_b  = sh_b - trial_b;
        root_b = {root_a[WW-2:0], 1'b1};
      end else begin
        rem_b  = sh_b;
        root_b = {root_a[WW-2:0], 1'b0};
      end
    end

    // one horner step in the first nine stages, then carry the sum
    if (g < 9) begin : g_horner
      logic [WW+AccW-1:0] prod;
      assign prod  = WW'(u_q[g]) * acc_q[g];
      assign acc_n = AccW'(prod >> isa_pkg::WBits) + isa_pkg::Coef[8 - g];
    end else begin : g_carry
      assign acc_n = acc_q[g];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[g+1]  <= rem_b;
        root_q[g+1] <= root_b;
        rad_q[g+1]  <= rad_q[g] << 4;
        u_q[g+1]    <= u_q[g];
        acc_q[g+1]  <= acc_n;
      end
    end
  end

  // t = s * acc, then x = t * k, then round
  logic [WW+AccW-1:0] t_full, x_full;
  logic [AccW-1:0]    t_q;
  logic [AccW-1:0]    x_q;
  logic [isa_pkg::OutW-1:0] ang_q;
  localparam int unsigned Sh = isa_pkg::WBits - isa_pkg::FracBits;
  always_comb begin
    t_full = root_q[NSq] * acc_q[NSq];
    x_full = t_q * isa_pkg::SqrtThreeHalves;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q   <= AccW'(t_full >> isa_pkg::WBits);
      x_q   <= AccW'(x_full >> isa_pkg::WBits);
      ang_q <= isa_pkg::OutW'((x_q + AccW'(1 << (Sh - 1))) >> Sh);
    end
  end

  // root uses 31 bits; sqrt(2^60)=2^30 fits
  assign valid_o = vld_q[L];
  assign angle_o = ang_q;

endmodule

### tb/sv/inverse_sinc_approx_checker.sv
module inverse_sinc_approx_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic                     stall_o,
  input  logic [isa_pkg::InW-1:0]  sinc_value_i,
  input  logic                     valid_o,
  input  logic                     stall_i,
  input  logic [isa_pkg::OutW-1:0] angle_o,
  output int                       errors_o,
  output int                       pending_o,
  output int                       angles_seen_o
);

  localparam logic [63:0] OneW = 64'd1 << isa_pkg::WBits;

  logic [isa_pkg::OutW-1:0] angle_q [$];

  // integer square root of a 64-bit value, bit by bit
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] b;
    root = '0;
    b    = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v    = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // angle with sinc(angle) = a from the truncated series in sqrt(1 - a)
  function automatic logic [isa_pkg::OutW-1:0] inverse_sinc(logic [isa_pkg::InW-1:0] a_in);
    logic [63:0] a, u, s, acc, t, x, one_in;
    one_in = 64'd1 << isa_pkg::FracBits;
    a = 64'(a_in);
    if (a > one_in) a = one_in;
    u = (one_in - a) << (isa_pkg::WBits - isa_pkg::FracBits);
    if (u > OneW) u = OneW;
    s = int_sqrt(u << isa_pkg::WBits);
    acc = 64'(isa_pkg::Coef[isa_pkg::NCoef-1]);
    for (int k = isa_pkg::NCoef - 2; k >= 0; k--)
      acc = ((acc * u) >> isa_pkg::WBits) + 64'(isa_pkg::Coef[k]);
    t = (s * acc) >> isa_pkg::WBits;
    x = (t * 64'(isa_pkg::SqrtThreeHalves)) >> isa_pkg::WBits;
    x = (x + (64'd1 << (isa_pkg::WBits - isa_pkg::FracBits - 1)))
        >> (isa_pkg::WBits - isa_pkg::FracBits);
    return x[isa_pkg::OutW-1:0];
  endfunction

  // predict on input transaction, compare on output transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      errors_o      <= 0;
      angles_seen_o <= 0;
      angle_q.delete();
    end else begin
      if (valid_i && !stall_o) angle_q.push_back(inverse_sinc(sinc_value_i));
      if (valid_o && !stall_i) begin
        angles_seen_o <= angles_seen_o + 1;
        if (angle_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected angle %0d", angle_o);
          errors_o <= errors_o + 1;
        end else begin
          if (angle_o !== angle_q[0]) begin
            if (errors_o < 10)
              $display("angle mismatch: expected %0d got %0d", angle_q[0], angle_o);
            errors_o <= errors_o + 1;
          end
          void'(angle_q.pop_front());
        end
      end
    end
  end

  always_comb pending_o = angle_q.size();
endmodule

### tb/sv/inverse_sinc_approx_test.sv
module inverse_sinc_approx_test;

  localparam int InW = isa_pkg::InW;
  localparam int OutW = isa_pkg::OutW;
  localparam int OneIn = 1 << isa_pkg::FracBits;
  localparam int CycleLimit = 400000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            valid_i = 1'b0;
  logic            stall_o;
  logic [InW-1:0]  sinc_value_i = '0;
  logic            valid_o;
  logic            stall_i = 1'b0;
  logic [OutW-1:0] angle_o;
  int              errors, pending, angles_seen;
  int              send_idle_pct = 0, recv_idle_pct = 0;
  bit              hold_off = 1'b0;
  int              cycles = 0;
  int              items_sent = 0;

  always #4 clk_i = ~clk_i;

  inverse_sinc_approx i_dut (.*);

  inverse_sinc_approx_checker i_checker (
    .clk_i, .rst_ni, .valid_i, .stall_o, .sinc_value_i, .valid_o, .stall_i, .angle_o,
    .errors_o(errors), .pending_o(pending), .angles_seen_o(angles_seen)
  );

  // receiver stall, random or a long hold-off
  always @(negedge clk_i) begin
    stall_i <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // offer one transaction, with random gaps before it
  task automatic send_value(logic [InW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i      <= 1'b1;
    sinc_value_i <= v;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // mostly in range, some above one, some near the ends
  function automatic logic [InW-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 75) return InW'($urandom_range(OneIn));
    if (r < 85) return InW'($urandom_range((1 << InW) - 1, OneIn + 1));
    if (r < 93) return InW'($urandom_range(64));
    return InW'(OneIn - $urandom_range(64));
  endfunction

  task automatic wait_drained();
    valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: ends, above one, single bits
    send_value('0);
    send_value(InW'(1));
    send_value(InW'(OneIn));
    send_value(InW'(OneIn - 1));
    send_value(InW'(OneIn + 1));
    send_value('1);
    send_value(InW'(OneIn / 2));
    for (int b = 0; b < InW; b++) send_value(InW'(1) << b);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 50; i++) send_value(pick_value());
    join
    // sender pauses until everything has come back
    wait_drained();

    send_idle_pct = 11; recv_idle_pct = 68;
    for (int i = 0; i < 530; i++) send_value(pick_value());
    send_idle_pct = 68; recv_idle_pct = 11;
    for (int i = 0; i < 530; i++) send_value(pick_value());
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 530; i++) send_value(pick_value());

    wait_drained();
    $display("sent %0d sinc values, checked %0d angles, incl. saturation and hold-off",
             items_sent, angles_seen);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### filelist.f
hdl/isa_pkg.sv
hdl/inverse_sinc_approx.sv
tb/sv/inverse_sinc_approx_checker.sv
tb/sv/inverse_sinc_approx_test.sv
